@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the parser top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check a property on every rising clk edge outside reset
`define CSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("csp assertion failed");
// check that a condition implies another on the same edge
`define CSP_IMPLY(lbl, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error("csp implication failed");
`else
`define CSP_ASSERT(lbl, prop)
`define CSP_IMPLY(lbl, cond, conseq)
`endif
`endif

@@ hw/rtl/csp_pkg.sv @@
// shared types, codes and helpers for the capture file stream parser
package csp_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PH_FILE,
    PH_RECORD,
    PH_PAYLOAD,
    PH_HALT
  } csp_phase_t;

  // input beat op codes
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SHORT_HDR = 3'd1;
  localparam logic [2:0] ERR_MAGIC     = 3'd2;
  localparam logic [2:0] ERR_VERSION   = 3'd3;
  localparam logic [2:0] ERR_TRUNC     = 3'd4;

  // magic numbers as read little-endian
  localparam logic [31:0] MAGIC_US      = 32'ha1b2c3d4;
  localparam logic [31:0] MAGIC_US_SWAP = 32'hd4c3b2a1;
  localparam logic [31:0] MAGIC_NS      = 32'ha1b23c4d;
  localparam logic [31:0] MAGIC_NS_SWAP = 32'h4d3cb2a1;

  localparam logic [15:0] VERSION_REQ = 16'd2;

  // header byte positions
  localparam logic [4:0] FILE_HDR_LAST = 5'd23;
  localparam logic [4:0] REC_HDR_LAST  = 5'd15;
  localparam logic [4:0] MAGIC_END     = 5'd4;
  localparam logic [4:0] VERSION_END   = 5'd6;
  localparam logic [4:0] SEC_END       = 5'd4;
  localparam logic [4:0] FRAC_END      = 5'd8;
  localparam logic [4:0] LEN_END       = 5'd12;

  // time scaling
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [9:0]  NS_PER_US  = 10'd1000;

  function automatic logic [31:0] flip32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [15:0] flip16(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

endpackage

@@ hw/rtl/capture_file_stream_parser.sv @@
// capture file stream parser top level
// Usage: feed the capture file one byte per input beat (in_op = 0, byte on
// in_data_byte), then one beat with in_op = 1 to mark the end of the stream.
// The 24-byte file header selects byte order and micro or nanosecond
// precision and checks major version 2. Each 16-byte record header yields
// the packet's timestamp and length; each payload byte then comes out as
// one result beat with length, timestamp in ns and first/last marks. An
// empty packet gives one result beat on its last header byte. A bad magic,
// bad version, short file header or truncated payload gives one error beat
// and the block then drops every input beat until reset.
// A beat goes from the input register through parse logic into the output
// register. Throughput: one beat per cycle while out_stall is low; the
// timestamp multiplier runs two stages behind the record header and is done
// long before the header's last byte.
// Reset (rst_n low, synchronous) returns the parser to the file header.
// When out_stall is high the output register holds and in_stall rises once
// the input register is also full, so no beat is lost.
module capture_file_stream_parser import csp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [31:0] out_packet_length,
  output logic [63:0] out_capture_ns,
  output logic        out_first_of_packet,
  output logic        out_last_of_packet,
  output logic [2:0]  out_error_code
);

`include "assert_macros.svh"

  // input register
  logic       in_v_r;
  logic       in_op_r;
  logic [7:0] in_byte_r;
  logic       in_acc;
  logic       adv;

  // parser state
  csp_phase_t  phase_r, phase_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [31:0] magic_r, magic_nxt;
  logic [15:0] version_r, version_nxt;
  logic        swap_r, swap_nxt;
  logic        nano_r, nano_nxt;
  logic [31:0] sec_r, sec_nxt;
  logic [31:0] frac_r, frac_nxt;
  logic [31:0] len_raw_r, len_raw_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] left_r, left_nxt;

  // output register
  logic        out_v_r;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  pbyte_r, pbyte_nxt;
  logic [31:0] plen_r, plen_nxt;
  logic [63:0] ts_r, ts_nxt;
  logic        first_r, first_nxt;
  logic        last_r, last_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        emit;

  // helpers
  logic [31:0] sec_eff, frac_eff, len_eff;
  logic [15:0] version_eff;
  logic [63:0] stamp;
  logic        magic_ok;

  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_acc) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
    if (in_acc) begin
      in_op_r   <= in_op;
      in_byte_r <= in_data_byte;
    end
  end

  // byte-order correction of captured header words
  assign sec_eff     = swap_r ? flip32(sec_r) : sec_r;
  assign frac_eff    = swap_r ? flip32(frac_r) : frac_r;
  assign len_eff     = swap_r ? flip32(len_raw_r) : len_raw_r;
  assign version_eff = swap_r ? flip16(version_r) : version_r;

  csp_stamp u_stamp (
    .clk     (clk),
    .sec_i   (sec_eff),
    .frac_i  (frac_eff),
    .nano_i  (nano_r),
    .stamp_o (stamp)
  );

  assign magic_ok = (magic_r == MAGIC_US) || (magic_r == MAGIC_NS) ||
                    (magic_r == MAGIC_US_SWAP) || (magic_r == MAGIC_NS_SWAP);

  // parse one beat
  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    magic_nxt   = magic_r;
    version_nxt = version_r;
    swap_nxt    = swap_r;
    nano_nxt    = nano_r;
    sec_nxt     = sec_r;
    frac_nxt    = frac_r;
    len_raw_nxt = len_raw_r;
    len_nxt     = len_r;
    left_nxt    = left_r;
    emit        = 1'b0;
    kind_nxt    = KIND_ERROR;
    pbyte_nxt   = 8'd0;
    plen_nxt    = 32'd0;
    ts_nxt      = 64'd0;
    first_nxt   = 1'b0;
    last_nxt    = 1'b0;
    err_nxt     = ERR_NONE;
    if (adv && phase_r != PH_HALT) begin
      if (in_op_r == OP_EOS) begin
        phase_nxt = PH_HALT;
        case (phase_r)
          PH_FILE: begin
            emit    = 1'b1;
            err_nxt = ERR_SHORT_HDR;
          end
          PH_PAYLOAD: begin
            emit    = 1'b1;
            err_nxt = ERR_TRUNC;
          end
          default: begin
          end
        endcase
      end else begin
        case (phase_r)
          PH_FILE: begin
            if (idx_r < MAGIC_END) begin
              magic_nxt = {in_byte_r, magic_r[31:8]};
            end else if (idx_r < VERSION_END) begin
              version_nxt = {in_byte_r, version_r[15:8]};
            end
            if (idx_r < FILE_HDR_LAST) begin
              idx_nxt = idx_r + 5'd1;
            end else begin
              idx_nxt  = 5'd0;
              swap_nxt = (magic_r == MAGIC_US_SWAP) || (magic_r == MAGIC_NS_SWAP);
              nano_nxt = (magic_r == MAGIC_NS) || (magic_r == MAGIC_NS_SWAP);
              if (!magic_ok) begin
                phase_nxt = PH_HALT;
                emit      = 1'b1;
                err_nxt   = ERR_MAGIC;
              end else if ((swap_nxt ? flip16(version_r) : version_r) != VERSION_REQ) begin
                phase_nxt = PH_HALT;
                emit      = 1'b1;
                err_nxt   = ERR_VERSION;
              end else begin
                phase_nxt = PH_RECORD;
              end
            end
          end
          PH_RECORD: begin
            if (idx_r < SEC_END) begin
              sec_nxt = {in_byte_r, sec_r[31:8]};
            end else if (idx_r < FRAC_END) begin
              frac_nxt = {in_byte_r, frac_r[31:8]};
            end else if (idx_r < LEN_END) begin
              len_raw_nxt = {in_byte_r, len_raw_r[31:8]};
            end
            if (idx_r < REC_HDR_LAST) begin
              idx_nxt = idx_r + 5'd1;
            end else begin
              idx_nxt = 5'd0;
              len_nxt = len_eff;
              if (len_eff == 32'd0) begin
                emit      = 1'b1;
                kind_nxt  = KIND_EMPTY;
                ts_nxt    = stamp;
                first_nxt = 1'b1;
                last_nxt  = 1'b1;
              end else begin
                left_nxt  = len_eff;
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            emit      = 1'b1;
            kind_nxt  = KIND_PAYLOAD;
            pbyte_nxt = in_byte_r;
            plen_nxt  = len_r;
            ts_nxt    = stamp;
            first_nxt = (left_r == len_r);
            last_nxt  = (left_r == 32'd1);
            left_nxt  = left_r - 32'd1;
            if (left_r == 32'd1) begin
              phase_nxt = PH_RECORD;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_FILE;
      idx_r     <= 5'd0;
      magic_r   <= 32'd0;
      version_r <= 16'd0;
      swap_r    <= 1'b0;
      nano_r    <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      magic_r   <= magic_nxt;
      version_r <= version_nxt;
      swap_r    <= swap_nxt;
      nano_r    <= nano_nxt;
    end
    sec_r     <= sec_nxt;
    frac_r    <= frac_nxt;
    len_raw_r <= len_raw_nxt;
    len_r     <= len_nxt;
    left_r    <= left_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (emit) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
    if (emit) begin
      kind_r  <= kind_nxt;
      pbyte_r <= pbyte_nxt;
      plen_r  <= plen_nxt;
      ts_r    <= ts_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      err_r   <= err_nxt;
    end
  end

  assign out_valid           = out_v_r;
  assign out_kind            = kind_r;
  assign out_payload_byte    = pbyte_r;
  assign out_packet_length   = plen_r;
  assign out_capture_ns      = ts_r;
  assign out_first_of_packet = first_r;
  assign out_last_of_packet  = last_r;
  assign out_error_code      = err_r;

  // checks
  `CSP_IMPLY(a_err_halts, out_v_r && kind_r == KIND_ERROR, phase_r == PH_HALT)
  `CSP_IMPLY(a_payload_no_err, out_v_r && kind_r != KIND_ERROR, err_r == ERR_NONE)
  `CSP_IMPLY(a_payload_left, phase_r == PH_PAYLOAD, left_r != 32'd0 && left_r <= len_r)
  `CSP_IMPLY(a_rec_idx, phase_r == PH_RECORD || phase_r == PH_PAYLOAD, idx_r <= REC_HDR_LAST)
  `CSP_ASSERT(a_no_emit_stalled, !(emit && out_v_r && out_stall))

endmodule

@@ hw/rtl/csp_stamp.sv @@
// two-stage timestamp unit: seconds times 1e9 plus scaled fraction
module csp_stamp import csp_pkg::*; (
  input  logic        clk,
  input  logic [31:0] sec_i,
  input  logic [31:0] frac_i,
  input  logic        nano_i,
  output logic [63:0] stamp_o
);

  logic [61:0] prod_r, prod_nxt;
  logic [41:0] frac_r, frac_nxt;
  logic [63:0] stamp_r, stamp_nxt;

  // multiply stage
  always_comb begin
    prod_nxt = 62'(sec_i) * 62'(NS_PER_SEC);
    if (nano_i) begin
      frac_nxt = 42'(frac_i);
    end else begin
      frac_nxt = 42'(frac_i) * 42'(NS_PER_US);
    end
  end

  // sum stage
  assign stamp_nxt = 64'(prod_r) + 64'(frac_r);

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    frac_r  <= frac_nxt;
    stamp_r <= stamp_nxt;
  end

  assign stamp_o = stamp_r;

endmodule
